// File: src/bpfa_pkg.sv
package bpfa_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_IDX_W = 5;
   localparam int ACTION_W  = 2;
   localparam int PAGE_IN_W = 16;
   localparam int ADDR_W    = 27;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_RESERVE = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_OOM   = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_RD_MAP,
      S_MOD_MAP
   } state_type;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [PAGE_IN_W-1:0] page_index;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   page_address;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  free_total;
   } rsp_type;

   typedef struct packed {
      logic                 any;
      logic [BIT_IDX_W-1:0] idx;
   } ffs_type;

endpackage

// File: src/bitmap_page_frame_allocator.sv
// sequence: free and reserve read the map word, write it back, then strobe the result; out of
//   range, unused action and allocate with no free page are answered straight from idle;
//   allocate first scans the summary words (at most MAP_WORDS/32, rounded up) before its map update
// throughput: one request at a time, the next is accepted in the cycle its result shows
// reset: synchronous; a clearing pass zeroes the map and summary memories with busy high;
//   results are strobed and the receiver cannot stall them
module bitmap_page_frame_allocator #(
   parameter int MAP_WORDS  = 1024,
   parameter int PAGE_SHIFT = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bpfa_pkg::req_type req_data,
   output logic              rsp_strobe,
   output bpfa_pkg::rsp_type rsp_data
);

   // sizes
   localparam int PAGES      = MAP_WORDS * bpfa_pkg::WORD_BITS;
   localparam int SUM_WORDS  = (MAP_WORDS + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
   localparam int MAP_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SUM_IDX_W  = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
   localparam int CNT_W      = $clog2(PAGES + 1);
   localparam int PAGE_W     = MAP_IDX_W + bpfa_pkg::BIT_IDX_W;
   localparam int ADDR_EXT_W = PAGE_W + PAGE_SHIFT + bpfa_pkg::ADDR_W;

   // bitmap, one bit per page, 1 = free
   logic [bpfa_pkg::WORD_BITS-1:0] map_mem [MAP_WORDS];
   // summary, one bit per map word, 1 = word has a free page
   logic [bpfa_pkg::WORD_BITS-1:0] sum_mem [SUM_WORDS];

   bpfa_pkg::state_type state_ff, state_in;

   logic [MAP_IDX_W-1:0]           clr_ff, clr_in;
   logic [SUM_IDX_W-1:0]           scan_ff, scan_in;
   logic [SUM_IDX_W-1:0]           chk_idx_ff, chk_idx_in;
   logic                           chk_ff, chk_in;
   logic [MAP_IDX_W-1:0]           word_ff, word_in;
   logic [bpfa_pkg::BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [bpfa_pkg::ACTION_W-1:0]  act_ff, act_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   bpfa_pkg::rsp_type              rsp_ff, rsp_in;

   // memory ports
   logic [bpfa_pkg::WORD_BITS-1:0] map_rd_ff, sum_rd_ff;
   logic                           map_we, sum_we;
   logic [MAP_IDX_W-1:0]           map_waddr;
   logic [SUM_IDX_W-1:0]           sum_waddr, sum_raddr;
   logic [bpfa_pkg::WORD_BITS-1:0] map_wdata, sum_wdata;

   // shared search unit
   logic [bpfa_pkg::WORD_BITS-1:0] ffs_data;
   bpfa_pkg::ffs_type              ffs_res;

   // request decode
   logic                 accept;
   logic                 in_range;
   logic [MAP_IDX_W-1:0] req_word;

   // scan and update helpers
   logic                           scan_hit, scan_done;
   logic [SUM_IDX_W-1:0]           word_sum_idx;
   logic [bpfa_pkg::BIT_IDX_W-1:0] bit_sel, sum_bit;
   logic [bpfa_pkg::WORD_BITS-1:0] bit_mask, new_word, sum_mask;
   logic                           old_set;
   logic [CNT_W-1:0]               count_upd;
   logic [PAGE_W-1:0]              found_page;
   logic [ADDR_EXT_W-1:0]          addr_ext;

   bpfa_ffs u_ffs (
      .data   (ffs_data),
      .result (ffs_res)
   );

   assign accept   = start && (state_ff == bpfa_pkg::S_IDLE);
   assign in_range = 32'(req_data.page_index) < PAGES;
   assign req_word = MAP_IDX_W'(req_data.page_index >> bpfa_pkg::BIT_IDX_W);

   // search unit sees the summary word while scanning, the map word otherwise
   assign ffs_data = (state_ff == bpfa_pkg::S_SCAN) ? sum_rd_ff : map_rd_ff;

   assign scan_hit  = chk_ff && ffs_res.any;
   assign scan_done = chk_ff && (chk_idx_ff == SUM_IDX_W'(SUM_WORDS - 1));

   assign word_sum_idx = SUM_IDX_W'(word_ff >> bpfa_pkg::BIT_IDX_W);
   assign sum_bit      = bpfa_pkg::BIT_IDX_W'(word_ff);
   assign sum_mask     = bpfa_pkg::WORD_BITS'(1) << sum_bit;

   // read-modify-write of one map word
   assign bit_sel  = (act_ff == bpfa_pkg::ACT_ALLOC) ? ffs_res.idx : bit_ff;
   assign bit_mask = bpfa_pkg::WORD_BITS'(1) << bit_sel;
   assign old_set  = |(map_rd_ff & bit_mask);
   assign new_word = (act_ff == bpfa_pkg::ACT_FREE) ? (map_rd_ff | bit_mask)
                                                    : (map_rd_ff & ~bit_mask);

   // count moves only when the bit really flips
   always_comb begin
      count_upd = count_ff;
      if (act_ff == bpfa_pkg::ACT_FREE) begin
         if (!old_set) begin
            count_upd = count_ff + CNT_W'(1);
         end
      end else if (old_set) begin
         count_upd = count_ff - CNT_W'(1);
      end
   end

   assign found_page = {word_ff, bit_sel};
   assign addr_ext   = ADDR_EXT_W'(found_page) << PAGE_SHIFT;

   assign sum_raddr = (state_ff == bpfa_pkg::S_SCAN) ? scan_ff : word_sum_idx;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpfa_pkg::S_CLEAR: begin
            if (clr_ff == MAP_IDX_W'(MAP_WORDS - 1)) begin
               state_in = bpfa_pkg::S_IDLE;
            end
         end
         bpfa_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_data.action)
                  bpfa_pkg::ACT_ALLOC: begin
                     if (count_ff != '0) begin
                        state_in = bpfa_pkg::S_SCAN;
                     end
                  end
                  bpfa_pkg::ACT_FREE, bpfa_pkg::ACT_RESERVE: begin
                     if (in_range) begin
                        state_in = bpfa_pkg::S_RD_MAP;
                     end
                  end
                  default: state_in = bpfa_pkg::S_IDLE;
               endcase
            end
         end
         bpfa_pkg::S_SCAN: begin
            if (scan_hit) begin
               state_in = bpfa_pkg::S_RD_MAP;
            end else if (scan_done) begin
               state_in = bpfa_pkg::S_IDLE;
            end
         end
         bpfa_pkg::S_RD_MAP:  state_in = bpfa_pkg::S_MOD_MAP;
         bpfa_pkg::S_MOD_MAP: state_in = bpfa_pkg::S_IDLE;
         default:             state_in = bpfa_pkg::S_CLEAR;
      endcase
   end

   // datapath and memory writes
   always_comb begin
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      chk_idx_in    = chk_idx_ff;
      chk_in        = chk_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      act_in        = act_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      map_we        = 1'b0;
      map_waddr     = word_ff;
      map_wdata     = new_word;
      sum_we        = 1'b0;
      sum_waddr     = word_sum_idx;
      sum_wdata     = new_word != '0 ? (sum_rd_ff | sum_mask) : (sum_rd_ff & ~sum_mask);

      unique case (state_ff)
         bpfa_pkg::S_CLEAR: begin
            // one map word a cycle, summary words alongside
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            sum_we    = 32'(clr_ff) < SUM_WORDS;
            sum_waddr = SUM_IDX_W'(clr_ff);
            sum_wdata = '0;
            clr_in    = clr_ff + MAP_IDX_W'(1);
         end
         bpfa_pkg::S_IDLE: begin
            if (accept) begin
               act_in  = req_data.action;
               word_in = req_word;
               bit_in  = req_data.page_index[bpfa_pkg::BIT_IDX_W-1:0];
               scan_in = '0;
               chk_in  = 1'b0;
               rsp_in.page_address = '0;
               rsp_in.status       = bpfa_pkg::STAT_OK;
               rsp_in.free_total   = bpfa_pkg::COUNT_W'(count_ff);
               unique case (req_data.action)
                  bpfa_pkg::ACT_ALLOC: begin
                     // nothing free: answer at once
                     if (count_ff == '0) begin
                        rsp_in.status = bpfa_pkg::STAT_OOM;
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  bpfa_pkg::ACT_FREE, bpfa_pkg::ACT_RESERVE: begin
                     if (!in_range) begin
                        rsp_in.status = bpfa_pkg::STAT_RANGE;
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: rsp_strobe_in = 1'b1;
               endcase
            end
         end
         bpfa_pkg::S_SCAN: begin
            // read of scan_ff in flight while the previous summary word is checked
            if (scan_hit) begin
               word_in = MAP_IDX_W'({chk_idx_ff, ffs_res.idx});
            end else if (scan_done) begin
               rsp_in.page_address = '0;
               rsp_in.status       = bpfa_pkg::STAT_OOM;
               rsp_in.free_total   = bpfa_pkg::COUNT_W'(count_ff);
               rsp_strobe_in       = 1'b1;
            end else begin
               chk_in     = 1'b1;
               chk_idx_in = scan_ff;
               if (scan_ff != SUM_IDX_W'(SUM_WORDS - 1)) begin
                  scan_in = scan_ff + SUM_IDX_W'(1);
               end
            end
         end
         bpfa_pkg::S_RD_MAP: begin
            // map and summary words for word_ff arrive next cycle
         end
         bpfa_pkg::S_MOD_MAP: begin
            map_we   = 1'b1;
            sum_we   = 1'b1;
            count_in = count_upd;
            rsp_in.page_address = (act_ff == bpfa_pkg::ACT_ALLOC)
                                  ? addr_ext[bpfa_pkg::ADDR_W-1:0] : '0;
            rsp_in.status       = bpfa_pkg::STAT_OK;
            rsp_in.free_total   = bpfa_pkg::COUNT_W'(count_upd);
            rsp_strobe_in       = 1'b1;
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[word_ff];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bpfa_pkg::S_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         chk_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         chk_ff        <= chk_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      word_ff    <= word_in;
      bit_ff     <= bit_in;
      act_ff     <= act_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = state_ff != bpfa_pkg::S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a result only ever shows once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == bpfa_pkg::S_IDLE)
      else $error("result strobed while sequencer busy");

   // free count never exceeds the number of pages
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= PAGES)
      else $error("free count above page total");

   // summary pointed at a word that really holds a free page
   a_alloc_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpfa_pkg::S_MOD_MAP && act_ff == bpfa_pkg::ACT_ALLOC) |-> map_rd_ff != '0)
      else $error("allocate landed on an empty map word");

   // out of memory is only reported when nothing is free
   a_oom_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == bpfa_pkg::STAT_OOM) |-> count_ff == '0)
      else $error("out of memory with free pages left");

   // clearing pass holds off requests straight after reset
   a_clear_busy: assert property (@(posedge clock)
      reset |=> busy)
      else $error("not busy after reset");

endmodule

// File: src/bpfa_ffs.sv
// lowest set bit of one word, shared by summary and map searches
module bpfa_ffs (
   input  logic [bpfa_pkg::WORD_BITS-1:0] data,
   output bpfa_pkg::ffs_type              result
);

   always_comb begin
      result.any = |data;
      result.idx = '0;
      for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (data[i]) begin
            result.idx = bpfa_pkg::BIT_IDX_W'(i);
         end
      end
   end

endmodule
